// ----- src/vfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Volume fade playback package
// Shared state type, control and status groups and beat layout constants.
// ----------------------------------------------------------------------------
package vfp_pkg;

   // Width of every request and response field that carries a volume or length.
   localparam int FIELD_W     = 16;

   // Request beat layout, lowest bit first.
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_PLAY    = 0;
   localparam int REQ_STOP    = 1;
   localparam int REQ_FADE    = 2;
   localparam int REQ_TGT_LO  = 3;
   localparam int REQ_TCK_LO  = 19;

   // Response beat layout, lowest bit first.
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PLAYING = 16;
   localparam int RSP_FADING  = 17;
   localparam int RSP_START   = 18;
   localparam int RSP_STOP    = 19;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic apply;
      logic mul_step;
      logic div_step;
      logic finish;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic ramp_now;
   } status_type;

endpackage

// ----- src/vfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Volume fade sequencer
// Steps each tick through request handling, a serial multiply and a serial
// divide for ramp ticks, and result hand-off; owns the stream handshakes.
// ----------------------------------------------------------------------------
module vfp_ctrl #(
   parameter int VOL_BITS = 16,
   parameter int DUR_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  vfp_pkg::status_type status,
   output vfp_pkg::cmd_type    cmd
);

   localparam int PROD_W = VOL_BITS + DUR_BITS;
   localparam int CNT_W  = $clog2(PROD_W);

   vfp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               valid_ff, valid_in;
   logic               accept;
   logic               out_free;

   assign req_tready = (state_ff == vfp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vfp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = status.ramp_now ? vfp_pkg::ST_MUL : vfp_pkg::ST_OUT;
            end
         end
         vfp_pkg::ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = vfp_pkg::ST_DIV;
            end
         end
         vfp_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = vfp_pkg::ST_DONE;
            end
         end
         vfp_pkg::ST_DONE: begin
            state_in = vfp_pkg::ST_OUT;
         end
         vfp_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = vfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vfp_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         vfp_pkg::ST_IDLE: cmd.apply    = accept;
         vfp_pkg::ST_MUL:  cmd.mul_step = 1'b1;
         vfp_pkg::ST_DIV:  cmd.div_step = 1'b1;
         vfp_pkg::ST_DONE: cmd.finish   = 1'b1;
         vfp_pkg::ST_OUT:  cmd.out_load = out_free;
         default:          cmd = '0;
      endcase
   end

   // Iteration counter: one multiply pass per length bit, one divide pass
   // per product bit.
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = CNT_W'(DUR_BITS - 1);
      end else if (state_ff == vfp_pkg::ST_MUL) begin
         cnt_in = (cnt_ff == '0) ? CNT_W'(PROD_W - 1) : cnt_ff - 1'b1;
      end else if (state_ff == vfp_pkg::ST_DIV) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // The response register stays full until the receiver takes the beat.
   always_comb begin
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vfp_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- src/vfp_datapath.sv -----
// ----------------------------------------------------------------------------
// Volume fade datapath
// Holds the playback flags and ramp state, applies the requests of a tick and
// evaluates the ramp with a shift-add multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module vfp_datapath #(
   parameter int VOL_BITS = 16,
   parameter int DUR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vfp_pkg::cmd_type                     cmd,
   output vfp_pkg::status_type                  status,
   input  logic [vfp_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic [vfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int PROD_W = VOL_BITS + DUR_BITS;
   localparam int TGT_W  = (VOL_BITS > vfp_pkg::FIELD_W) ? VOL_BITS : vfp_pkg::FIELD_W;
   localparam int TCK_W  = (DUR_BITS > vfp_pkg::FIELD_W) ? DUR_BITS : vfp_pkg::FIELD_W;
   localparam logic [VOL_BITS-1:0] VOL_MAX = '1;
   localparam logic [DUR_BITS-1:0] DUR_MAX = '1;
   localparam logic [DUR_BITS-1:0] DUR_ONE = {{(DUR_BITS-1){1'b0}}, 1'b1};
   localparam logic [vfp_pkg::FIELD_W-1:0] OUT_MAX = '1;

   // Request fields.
   logic                        play_req, stop_req, fade_req;
   logic [vfp_pkg::FIELD_W-1:0] fade_goal, fade_ticks;
   logic [VOL_BITS-1:0]         tgt_sat;
   logic [DUR_BITS-1:0]         tck_lim, tck_sat;

   // Architectural state.
   logic                playing_ff, playing_in;
   logic                fading_ff, fading_in;
   logic [VOL_BITS-1:0] level_ff, level_in;
   logic [VOL_BITS-1:0] rstart_ff, rstart_in;
   logic [VOL_BITS-1:0] rend_ff, rend_in;
   logic [DUR_BITS-1:0] rlen_ff, rlen_in;
   logic [DUR_BITS-1:0] rstep_ff, rstep_in;
   logic                start_ff, start_in;
   logic                stop_ff, stop_in;

   // Arithmetic work registers.
   logic [VOL_BITS-1:0] diff_ff, diff_in;
   logic                down_ff, down_in;
   logic [DUR_BITS-1:0] mul_ff, mul_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [DUR_BITS-1:0] rem_ff, rem_in;

   // Response register.
   logic [vfp_pkg::RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   // Request handling results.
   logic                a_playing, a_fading, a_start, a_stop;
   logic [VOL_BITS-1:0] a_rstart, a_rend;
   logic [DUR_BITS-1:0] a_rlen, a_rstep_pre, a_rstep;
   logic                a_fade_done;
   logic [DUR_BITS:0]   step_inc;

   logic [DUR_BITS:0]   rem_sh;
   logic                q_bit;
   logic [VOL_BITS-1:0] quot;
   logic [TGT_W-1:0]    level_wide;

   assign play_req    = req_tdata[vfp_pkg::REQ_PLAY];
   assign stop_req    = req_tdata[vfp_pkg::REQ_STOP];
   assign fade_req    = req_tdata[vfp_pkg::REQ_FADE];
   assign fade_goal   = req_tdata[vfp_pkg::REQ_TGT_LO +: vfp_pkg::FIELD_W];
   assign fade_ticks  = req_tdata[vfp_pkg::REQ_TCK_LO +: vfp_pkg::FIELD_W];

   // Saturate the target and length to the configured widths; zero length
   // counts as one tick.
   assign tgt_sat = (TGT_W'(fade_goal) > TGT_W'(VOL_MAX)) ? VOL_MAX
                                                            : VOL_BITS'(fade_goal);
   assign tck_lim = (TCK_W'(fade_ticks) > TCK_W'(DUR_MAX)) ? DUR_MAX
                                                             : DUR_BITS'(fade_ticks);
   assign tck_sat = (tck_lim == '0) ? DUR_ONE : tck_lim;

   // Stop, fade start and play, in that order, then the step count.
   always_comb begin
      a_playing   = playing_ff;
      a_fading    = fading_ff;
      a_start     = 1'b0;
      a_stop      = 1'b0;
      a_rstart    = rstart_ff;
      a_rend      = rend_ff;
      a_rlen      = rlen_ff;
      a_rstep_pre = rstep_ff;
      if (stop_req) begin
         a_playing = 1'b0;
         a_fading  = 1'b0;
         a_stop    = 1'b1;
      end
      if (fade_req) begin
         a_rstart    = level_ff;
         a_rend      = tgt_sat;
         a_rlen      = tck_sat;
         a_rstep_pre = '0;
         a_fading    = 1'b1;
         if (!a_playing && (tgt_sat != '0)) begin
            a_playing = 1'b1;
            a_start   = 1'b1;
         end
      end
      if (play_req && !a_playing) begin
         a_playing = 1'b1;
         a_start   = 1'b1;
      end
   end

   assign step_inc    = {1'b0, a_rstep_pre} + 1'b1;
   assign a_fade_done = (step_inc >= {1'b0, a_rlen});
   assign a_rstep     = !a_fading ? a_rstep_pre
                      : (a_fade_done ? a_rlen : step_inc[DUR_BITS-1:0]);

   assign status.ramp_now = a_fading;

   // One restoring divide step on the product.
   assign rem_sh = {rem_ff, acc_ff[PROD_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, rlen_ff});
   assign quot   = acc_ff[VOL_BITS-1:0];

   // State updates.
   always_comb begin
      playing_in = playing_ff;
      fading_in  = fading_ff;
      level_in   = level_ff;
      rstart_in  = rstart_ff;
      rend_in    = rend_ff;
      rlen_in    = rlen_ff;
      rstep_in   = rstep_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      if (cmd.apply) begin
         playing_in = a_playing;
         fading_in  = a_fading && !a_fade_done;
         rstart_in  = a_rstart;
         rend_in    = a_rend;
         rlen_in    = a_rlen;
         rstep_in   = a_rstep;
         start_in   = a_start;
         stop_in    = a_stop;
      end else if (cmd.finish) begin
         level_in = down_ff ? rstart_ff - quot : rstart_ff + quot;
         // A completed fade to silence ends playback.
         if (!fading_ff && (rend_ff == '0) && playing_ff) begin
            playing_in = 1'b0;
            stop_in    = 1'b1;
         end
      end
   end

   // Multiply the span by the step count, then divide by the length.
   always_comb begin
      diff_in = diff_ff;
      down_in = down_ff;
      mul_in  = mul_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (cmd.apply) begin
         down_in = (a_rend < a_rstart);
         diff_in = (a_rend < a_rstart) ? a_rstart - a_rend : a_rend - a_rstart;
         mul_in  = a_rstep;
         acc_in  = '0;
         rem_in  = '0;
      end else if (cmd.mul_step) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                + (mul_ff[DUR_BITS-1] ? PROD_W'(diff_ff) : '0);
         mul_in = {mul_ff[DUR_BITS-2:0], 1'b0};
      end else if (cmd.div_step) begin
         rem_in = q_bit ? DUR_BITS'(rem_sh - {1'b0, rlen_ff}) : rem_sh[DUR_BITS-1:0];
         acc_in = {acc_ff[PROD_W-2:0], q_bit};
      end
   end

   // Response beat, with the volume held to sixteen bits.
   assign level_wide = TGT_W'(level_ff);
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in = '0;
         rsp_in[vfp_pkg::FIELD_W-1:0] = (level_wide > TGT_W'(OUT_MAX)) ? OUT_MAX
                                       : level_wide[vfp_pkg::FIELD_W-1:0];
         rsp_in[vfp_pkg::RSP_PLAYING] = playing_ff;
         rsp_in[vfp_pkg::RSP_FADING]  = fading_ff;
         rsp_in[vfp_pkg::RSP_START]   = start_ff;
         rsp_in[vfp_pkg::RSP_STOP]    = stop_ff;
      end
   end

   assign rsp_tdata = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         fading_ff  <= 1'b0;
         level_ff   <= '0;
         rstart_ff  <= '0;
         rend_ff    <= '0;
         rlen_ff    <= DUR_ONE;
         rstep_ff   <= '0;
         start_ff   <= 1'b0;
         stop_ff    <= 1'b0;
      end else begin
         playing_ff <= playing_in;
         fading_ff  <= fading_in;
         level_ff   <= level_in;
         rstart_ff  <= rstart_in;
         rend_ff    <= rend_in;
         rlen_ff    <= rlen_in;
         rstep_ff   <= rstep_in;
         start_ff   <= start_in;
         stop_ff    <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      down_ff <= down_in;
      mul_ff  <= mul_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- src/volume_fade_playback_controller.sv -----
// ----------------------------------------------------------------------------
// Volume fade playback controller
// Per-tick playback flags and a linear volume ramp with automatic fade-out
// stop, built from a sequencer and an arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request beat per 16 ms tick on the req_ channel. Each beat holds
//   play, stop and fade requests plus a fade target and length. The block
//   answers every request with exactly one beat on the rsp_ channel carrying
//   the volume, the playing and fading flags and the start and stop pulses.
//   Within a tick, stop is handled first, then fade start, then play, then
//   one ramp step.
// Sequencing:
//   A tick with a ramp in progress runs a shift-add multiply and a restoring
//   divide over the product before its result is loaded into the response
//   register; a tick without a ramp goes straight to the response register.
//   A new request is accepted only once the block is back in idle, after the
//   previous response has been loaded.
// Reset:
//   Synchronous reset stops playback, clears the ramp (its length to one) and
//   the volume to zero and empties the response register.
// Stalls:
//   A finished response waits in its register while rsp_tready is low, and
//   the next request is still accepted; its result then waits until the
//   earlier beat is taken.
// ----------------------------------------------------------------------------
module volume_fade_playback_controller #(
   parameter int VOL_BITS = 16,
   parameter int DUR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // play_req[0], stop_req[1], fade_req[2], fade_goal[18:3],
   // fade_ticks[34:19], zero fill[39:35]
   input  logic [vfp_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // volume[15:0], is_playing[16], is_fading[17], start_pulse[18],
   // stop_pulse[19], zero fill[23:20]
   output logic [vfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   vfp_pkg::cmd_type    cmd;
   vfp_pkg::status_type status;

   // Sequencer and handshakes.
   vfp_ctrl #(
      .VOL_BITS (VOL_BITS),
      .DUR_BITS (DUR_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // State and arithmetic.
   vfp_datapath #(
      .VOL_BITS (VOL_BITS),
      .DUR_BITS (DUR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- src/vfp_checker.sv -----
// ----------------------------------------------------------------------------
// Volume fade port checker
// Watches the controller's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module vfp_port_checks (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [vfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // One request in flight: the cycle after acceptance the block is busy.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Playing after a stop pulse means playback restarted in the same tick.
   a_stop_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[vfp_pkg::RSP_STOP] && rsp_tdata[vfp_pkg::RSP_PLAYING]
      |-> rsp_tdata[vfp_pkg::RSP_START])
      else $error("playing after stop without start pulse");

   // A start that ends stopped must have been followed by a stop.
   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[vfp_pkg::RSP_START] && !rsp_tdata[vfp_pkg::RSP_PLAYING]
      |-> rsp_tdata[vfp_pkg::RSP_STOP])
      else $error("started but stopped without stop pulse");

endmodule

bind volume_fade_playback_controller vfp_port_checks u_vfp_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
